// ===== design/lru_key_value_cache_unit_macros.svh =====
// Assertion macros shared by the LRU key-value cache modules.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LRUKV_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, forces another one at the next clock edge.
`define LRUKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lrukv_pkg.sv =====
// Types and constants shared by the LRU key-value cache modules.
package lrukv_pkg;

    // Operation codes carried in the mode field.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Capacity register width and reset value.
    localparam int unsigned CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Value returned by a read that misses.
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    // One input request.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic               hit;
    } t_out_item;

    // Request from the pipeline control to the entry store.
    typedef struct packed {
        logic     en;
        t_in_item item;
    } t_store_req;

    // Answer of the entry store for the request now at its input.
    typedef struct packed {
        logic      give;
        t_out_item item;
    } t_store_rsp;

endpackage

// ===== design/lru_key_value_cache_unit.sv =====
// Requests wait in the input register; store lookup and update fit in the single compute stage.
// A read's result then goes to the output register. One request per cycle unless a read stalls.
// Writes give no result and never wait on the output side; reads wait only for a free output.
// Reset (synchronous, active low) clears all valid marks, ranks and the fill count at once,
// and sets the capacity register to sixteen; no clearing pass is needed.
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lrukv_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lrukv_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lrukv_pkg::CAP_W-1:0]   i_cfg_data
);

    logic                         r_in_valid;
    lrukv_pkg::t_in_item          r_in;
    logic                         r_out_valid;
    lrukv_pkg::t_out_item         r_out;
    logic [lrukv_pkg::CAP_W-1:0]  r_cap;

    lrukv_pkg::t_store_req        store_req;
    lrukv_pkg::t_store_rsp        store_rsp;
    logic                         out_free;
    logic                         advance;

    // The request in the input register moves on unless its result has nowhere to go.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = r_in_valid && (!store_rsp.give || out_free);
    assign o_in_stall = r_in_valid && !advance;

    assign store_req.en   = advance;
    assign store_req.item = r_in;

    lrukv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .i_cap   (r_cap),
        .o_rsp   (store_rsp)
    );

    // Capacity register; the port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lrukv_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && store_rsp.give) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && store_rsp.give) begin
            r_out <= store_rsp.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LRUKV_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, o_in_stall, r_in_valid && $stable(r_in), "held request lost")
    `LRUKV_ASSERT_NEXT(a_result_set, i_clk, i_rst_n, advance && store_rsp.give, r_out_valid, "read result not registered")
    `LRUKV_ASSERT_ALWAYS(a_miss_value, i_clk, i_rst_n, !r_out_valid || r_out.hit || (r_out.read_value == lrukv_pkg::MISS_VALUE), "miss without miss value")

endmodule

// ===== design/lrukv_store.sv =====
// Entry store of the LRU key-value cache: keys, values, valid marks and recency ranks.
`include "lru_key_value_cache_unit_macros.svh"

module lrukv_store #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrukv_pkg::t_store_req         i_req,
    input  logic [lrukv_pkg::CAP_W-1:0]   i_cap,
    output lrukv_pkg::t_store_rsp         o_rsp
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int CW = (FW > lrukv_pkg::CAP_W) ? FW : lrukv_pkg::CAP_W;

    logic signed [31:0] r_key [ENTRIES];
    logic signed [31:0] r_val [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [RW-1:0]      r_rank [ENTRIES];
    logic [FW-1:0]      r_fill;

    logic [ENTRIES-1:0] n_valid;
    logic [RW-1:0]      n_rank [ENTRIES];
    logic [FW-1:0]      n_fill;

    logic [CW-1:0]      cap_eff;
    logic               cap_nz;
    logic               active;
    logic [ENTRIES-1:0] match;
    logic               hit;
    logic signed [31:0] hit_val;
    logic [RW-1:0]      hit_rank;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] victim_oh;
    logic [RW-1:0]      last_rank;
    logic               has_room;
    logic [ENTRIES-1:0] tgt_oh;
    logic [ENTRIES-1:0] we_oh;
    logic [RW-1:0]      thr;
    logic               inc_all;
    logic               upd_rank;
    logic [ENTRIES-1:0] rank_bad;

    // Effective capacity, saturated to the number of slots.
    always_comb begin
        if (CW'(i_cap) > CW'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end else begin
            cap_eff = CW'(i_cap);
        end
    end

    assign cap_nz   = (cap_eff != '0);
    assign active   = i_req.en && cap_nz;
    assign has_room = CW'(r_fill) < cap_eff;
    assign last_rank = RW'(r_fill - FW'(1));

    // Parallel key compare, hit data and rank selection.
    always_comb begin
        logic seen;
        hit_val  = '0;
        hit_rank = '0;
        seen     = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]     = r_valid[i] && (r_key[i] == i_req.item.key);
            victim_oh[i] = r_valid[i] && (r_rank[i] == last_rank);
            free_oh[i]   = !r_valid[i] && !seen;
            if (!r_valid[i]) begin
                seen = 1'b1;
            end
            if (match[i]) begin
                hit_val  = hit_val | r_val[i];
                hit_rank = hit_rank | r_rank[i];
            end
        end
    end

    assign hit = |match;

    // Response for the request at the input, valid whether or not it is taken.
    always_comb begin
        o_rsp.give            = cap_nz && (i_req.item.mode == lrukv_pkg::MODE_READ);
        o_rsp.item.hit        = hit;
        o_rsp.item.read_value = hit ? hit_val : lrukv_pkg::MISS_VALUE;
    end

    // Choose the slot to touch and how the other ranks age.
    always_comb begin
        tgt_oh   = '0;
        we_oh    = '0;
        thr      = hit_rank;
        inc_all  = 1'b0;
        upd_rank = 1'b0;
        n_valid  = r_valid;
        n_fill   = r_fill;
        if (active) begin
            if (hit) begin
                tgt_oh   = match;
                upd_rank = 1'b1;
                if (i_req.item.mode == lrukv_pkg::MODE_WRITE) begin
                    we_oh = match;
                end
            end else if (i_req.item.mode == lrukv_pkg::MODE_WRITE) begin
                upd_rank = 1'b1;
                if (has_room) begin
                    tgt_oh  = free_oh;
                    we_oh   = free_oh;
                    inc_all = 1'b1;
                    n_valid = r_valid | free_oh;
                    n_fill  = r_fill + FW'(1);
                end else begin
                    tgt_oh = victim_oh;
                    we_oh  = victim_oh;
                    thr    = last_rank;
                end
            end
        end
    end

    // Rank update: the touched slot becomes most recent, younger entries age by one.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (upd_rank) begin
                if (tgt_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (inc_all || (r_rank[i] < thr))) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
        end
    end

    // Control state: valid marks, ranks and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_fill  <= n_fill;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Key and value storage, written only at the selected slot.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (we_oh[i]) begin
                r_key[i] <= i_req.item.key;
                r_val[i] <= i_req.item.value;
            end
        end
    end

    // Every valid entry must hold a rank below the fill count.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            rank_bad[i] = r_valid[i] && (FW'(r_rank[i]) >= r_fill);
        end
    end

    `LRUKV_ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill <= FW'(ENTRIES), "fill count exceeds slots")
    `LRUKV_ASSERT_ALWAYS(a_fill_count, i_clk, i_rst_n, $countones(r_valid) == int'(r_fill), "fill count differs from valid marks")
    `LRUKV_ASSERT_ALWAYS(a_rank_range, i_clk, i_rst_n, rank_bad == '0, "valid entry rank out of range")

endmodule
